FILE: rtl/twq_pkg.sv
package twq_pkg;

	// Field widths
	localparam int unsigned FUNC_W = 3;
	localparam int unsigned ID_W   = 16;
	localparam int unsigned TICK_W = 16;
	localparam int unsigned KIND_W = 4;

	// Queue sizing
	localparam int unsigned DEF_QUEUE_DEPTH = 16;
	localparam int unsigned MAX_RESULTS     = 16;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_ENQ  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_DEQ  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_FIND = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_DEL  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_TICK = 3'd4;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_DEQ      = 4'd0;
	localparam logic [KIND_W-1:0] KIND_EMPTY    = 4'd1;
	localparam logic [KIND_W-1:0] KIND_FOUND    = 4'd2;
	localparam logic [KIND_W-1:0] KIND_NOTFOUND = 4'd3;
	localparam logic [KIND_W-1:0] KIND_DELETED  = 4'd4;
	localparam logic [KIND_W-1:0] KIND_DELMISS  = 4'd5;
	localparam logic [KIND_W-1:0] KIND_EXPIRED  = 4'd6;
	localparam logic [KIND_W-1:0] KIND_ENQ      = 4'd7;
	localparam logic [KIND_W-1:0] KIND_FULL     = 4'd8;

	// One queue entry
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TICK_W-1:0] ticks;
		logic              expired;
	} entry_t;

	// Per-cycle command to every cell
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_LOAD,
		CMD_ROT,
		CMD_DROP
	} cmd_t;

	// Control bundle broadcast along the chain
	typedef struct packed {
		cmd_t   cmd;
		entry_t load;
		entry_t wrap;
	} cell_ctl_t;

endpackage

FILE: rtl/thread_wait_queue.sv
// Thread wait queue: an ordered queue of thread entries held in a chain of
// cells, entry 0 (the head) in the first cell.
// Input: a transaction is taken when start is high and busy is low; func,
// thread_id and wait_ticks are sampled at that edge.
// Output: each result sits on kind, thread_id_out and last for one cycle,
// marked by result_valid; last flags the final result of a transaction.
// Enqueue and dequeue: one result the cycle after acceptance, busy stays low,
// so a new transaction may follow every cycle.
// Find, delete and tick: the chain rotates once per cycle, the head cell is
// inspected and rewound to the tail (a delete drops its first match instead),
// and busy stays high through the walk and a finish state. Each expiry of a
// tick is held until the next one is found, then reported while the rotation
// runs; the final expiry and the answer to a find or delete come as busy falls.
// A tick that expires nothing, or any tick on an empty queue, gives no result.
// At most MAX_RESULTS expiries are reported per tick.
// Unused func codes are taken and ignored.
// Reset empties the queue and clears all control state; no clearing pass.
// The receiver cannot stall: results are never held back.
module thread_wait_queue import twq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [FUNC_W-1:0] func,
	input  logic [ID_W-1:0]   thread_id,
	input  logic [TICK_W-1:0] wait_ticks,
	output logic              result_valid,
	output logic [KIND_W-1:0] kind,
	output logic [ID_W-1:0]   thread_id_out,
	output logic              last
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned RES_W = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [FUNC_W-1:0] op_q;
	logic [ID_W-1:0]   key_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  step_q;
	logic              hit_q;
	logic              pend_valid_q;
	logic [ID_W-1:0]   pend_id_q;
	logic [RES_W-1:0]  nres_q;
	logic              res_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [ID_W-1:0]   res_id_q;
	logic              last_q;

	entry_t    cell_data  [QUEUE_DEPTH];
	logic      cell_valid [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] valid_vec;
	cell_ctl_t ctl;
	entry_t    head;
	logic      accept;
	logic      full;
	logic      empty;
	logic      match;
	logic      expire_now;
	logic      last_step;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign head     = cell_data[0];
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign match    = (head.id == key_q);
	assign expire_now = (head.ticks == TICK_W'(1));
	assign last_step  = (step_q == CNT_W'(total_q - 1'b1));

	// Build the chain
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t nxt;
		logic   nxt_valid;
		logic   prv_valid;

		if (i == QUEUE_DEPTH - 1) begin : g_end
			assign nxt       = '0;
			assign nxt_valid = 1'b0;
		end else begin : g_mid
			assign nxt       = cell_data[i+1];
			assign nxt_valid = cell_valid[i+1];
		end

		if (i == 0) begin : g_first
			assign prv_valid = 1'b1;
		end else begin : g_rest
			assign prv_valid = cell_valid[i-1];
		end

		twq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_valid (prv_valid),
			.next_in    (nxt),
			.next_valid (nxt_valid),
			.cur        (cell_data[i]),
			.cur_valid  (cell_valid[i])
		);

		assign valid_vec[i] = cell_valid[i];
	end

	// Drive the chain command; the head wraps to the tail during a walk
	always_comb begin
		ctl.cmd           = CMD_HOLD;
		ctl.load.id       = thread_id;
		ctl.load.ticks    = wait_ticks;
		ctl.load.expired  = 1'b0;
		ctl.wrap          = head;
		case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_ENQ && !full) ctl.cmd = CMD_LOAD;
				if (accept && func == FUNC_DEQ && !empty) ctl.cmd = CMD_DROP;
			end
			ST_WALK: begin
				ctl.cmd = CMD_ROT;
				if (op_q == FUNC_DEL && match && !hit_q) ctl.cmd = CMD_DROP;
				if (op_q == FUNC_TICK && head.ticks != '0) begin
					ctl.wrap.ticks   = head.ticks - 1'b1;
					ctl.wrap.expired = head.expired | expire_now;
				end
			end
			default: ;
		endcase
	end

	// Sequence operations and register results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= FUNC_ENQ;
			key_q        <= '0;
			count_q      <= '0;
			total_q      <= '0;
			step_q       <= '0;
			hit_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_id_q    <= '0;
			nres_q       <= '0;
			res_valid_q  <= 1'b0;
			kind_q       <= KIND_DEQ;
			res_id_q     <= '0;
			last_q       <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_ENQ: begin
								res_valid_q <= 1'b1;
								kind_q      <= full ? KIND_FULL : KIND_ENQ;
								res_id_q    <= thread_id;
								last_q      <= 1'b1;
								if (!full) count_q <= count_q + 1'b1;
							end
							FUNC_DEQ: begin
								res_valid_q <= 1'b1;
								kind_q      <= empty ? KIND_EMPTY : KIND_DEQ;
								res_id_q    <= empty ? '0 : head.id;
								last_q      <= 1'b1;
								if (!empty) count_q <= count_q - 1'b1;
							end
							FUNC_FIND, FUNC_DEL, FUNC_TICK: begin
								if (empty) begin
									if (func != FUNC_TICK) begin
										res_valid_q <= 1'b1;
										kind_q      <= (func == FUNC_FIND) ?
											KIND_NOTFOUND : KIND_DELMISS;
										res_id_q    <= '0;
										last_q      <= 1'b1;
									end
								end else begin
									state_q      <= ST_WALK;
									op_q         <= func;
									key_q        <= thread_id;
									total_q      <= count_q;
									step_q       <= '0;
									hit_q        <= 1'b0;
									pend_valid_q <= 1'b0;
									nres_q       <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					step_q <= step_q + 1'b1;
					if (last_step) state_q <= ST_FIN;
					case (op_q)
						FUNC_FIND: begin
							if (match) hit_q <= 1'b1;
						end
						FUNC_DEL: begin
							if (match && !hit_q) begin
								hit_q   <= 1'b1;
								count_q <= count_q - 1'b1;
							end
						end
						FUNC_TICK: begin
							// Hold each expiry until the next is found so the final one gets last
							if (expire_now && nres_q < RES_W'(MAX_RESULTS)) begin
								if (pend_valid_q) begin
									res_valid_q <= 1'b1;
									kind_q      <= KIND_EXPIRED;
									res_id_q    <= pend_id_q;
									last_q      <= 1'b0;
								end
								pend_valid_q <= 1'b1;
								pend_id_q    <= head.id;
								nres_q       <= nres_q + 1'b1;
							end
						end
						default: ;
					endcase
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
					case (op_q)
						FUNC_FIND: begin
							res_valid_q <= 1'b1;
							kind_q      <= hit_q ? KIND_FOUND : KIND_NOTFOUND;
							res_id_q    <= hit_q ? key_q : '0;
							last_q      <= 1'b1;
						end
						FUNC_DEL: begin
							res_valid_q <= 1'b1;
							kind_q      <= hit_q ? KIND_DELETED : KIND_DELMISS;
							res_id_q    <= hit_q ? key_q : '0;
							last_q      <= 1'b1;
						end
						FUNC_TICK: begin
							if (pend_valid_q) begin
								res_valid_q <= 1'b1;
								kind_q      <= KIND_EXPIRED;
								res_id_q    <= pend_id_q;
								last_q      <= 1'b1;
							end
						end
						default: ;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid  = res_valid_q;
	assign kind          = kind_q;
	assign thread_id_out = res_id_q;
	assign last          = last_q;

	// Occupied cells always match the entry count while the controller is idle
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> $countones(valid_vec) == 32'(count_q))
		else $error("cell occupancy disagrees with entry count");

	// Count never exceeds the queue depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	// Enqueue answers in the next cycle with a final result
	a_enq_answer: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == FUNC_ENQ |=> result_valid && last)
		else $error("enqueue gave no result");

	// Reported expiries per tick stay capped
	a_result_cap: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= RES_W'(MAX_RESULTS))
		else $error("too many expiries reported");

endmodule

FILE: rtl/twq_cell.sv
module twq_cell import twq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      prev_valid,
	input  entry_t    next_in,
	input  logic      next_valid,
	output entry_t    cur,
	output logic      cur_valid
);

	logic   valid_q;
	entry_t data_q;
	logic   is_free_slot;

	// The first empty cell takes a loaded entry
	assign is_free_slot = !valid_q && prev_valid;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.cmd)
				CMD_LOAD: begin
					if (is_free_slot) valid_q <= 1'b1;
				end
				CMD_DROP: begin
					if (valid_q && !next_valid) valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Advance payload: take the loaded entry, the neighbor's, or the wrapped head at the tail
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_LOAD: begin
				if (is_free_slot) data_q <= ctl.load;
			end
			CMD_ROT: begin
				if (valid_q) data_q <= next_valid ? next_in : ctl.wrap;
			end
			CMD_DROP: begin
				if (valid_q && next_valid) data_q <= next_in;
			end
			default: ;
		endcase
	end

	assign cur       = data_q;
	assign cur_valid = valid_q;

endmodule
